/* rtl/gmgs_pkg.sv */
// gmgs_pkg: shared types and constants for the motion gated gesture segmenter
// used by the class lanes, the argmax merge and the top level; no dependencies
package gmgs_pkg;

   localparam int DEFAULT_WINDOW      = 30;
   localparam int DEFAULT_NUM_CLASSES = 8;
   localparam int MAX_CLASSES         = 8;

   localparam int ENERGY_W = 32;
   localparam int SCORE_W  = 16;
   localparam int SUM_W    = 40;
   localparam int CLASS_W  = 4;
   localparam int FRAME_W  = 32;

   localparam logic [31:0] MARGIN_RESET = 32'd6554;

   localparam logic signed [SUM_W-1:0] SUM_MAX      = 40'sh7F_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN      = 40'sh80_0000_0000;
   localparam logic signed [SUM_W-1:0] ARGMAX_FLOOR = -40'sd25600000000;

   localparam logic signed [CLASS_W-1:0] NO_CLASS = 4'sb1111;

   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_FILL,
      KIND_STEADY
   } kind_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_ACC,
      ACT_END
   } action_type;

   typedef struct packed {
      logic acc;
      logic clr;
   } lane_ctrl_type;

endpackage

/* rtl/motion_gated_gesture_segmenter_unit.sv */
// motion_gated_gesture_segmenter_unit: top level, energy window, segment control
// depends on gmgs_pkg, gmgs_lane, gmgs_argmax
//
// One word per video frame enters on req_* (valid/ready): a motion energy and
// eight class scores, of which the first NUM_CLASSES are used. Exactly one word
// leaves on rsp_* per frame, in order. segment_done marks the frame that closed
// a segment; gesture_class then holds the winning class or -1, with the start
// and end frame numbers. The very first frame after reset only reports
// start_frame 1.
// csr_wr_en/csr_wr_data write the end margin (Q16.16); write it while idle.
// Throughput is one frame per cycle while the receiver keeps up. From acceptance
// to rsp_valid a frame passes the stage 1 registers and window memory read, then
// the window sum update and mean tests (the loop on the running sum), then the
// class lanes and argmax merge into the output register.
// When the receiver stalls, words fill the two inner stages and req_ready
// drops only once both are full behind the held output word.
// Reset (synchronous) clears the counters, flags, class sums and running sum;
// the window memory reads as zero until the first full-window frame, so no
// clearing pass.
module motion_gated_gesture_segmenter_unit
   import gmgs_pkg::*;
#(
   parameter int WINDOW      = DEFAULT_WINDOW,
   parameter int NUM_CLASSES = DEFAULT_NUM_CLASSES
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [31:0]                csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ENERGY_W-1:0]        req_motion_energy,
   input  logic signed [SCORE_W-1:0]  req_score_class0,
   input  logic signed [SCORE_W-1:0]  req_score_class1,
   input  logic signed [SCORE_W-1:0]  req_score_class2,
   input  logic signed [SCORE_W-1:0]  req_score_class3,
   input  logic signed [SCORE_W-1:0]  req_score_class4,
   input  logic signed [SCORE_W-1:0]  req_score_class5,
   input  logic signed [SCORE_W-1:0]  req_score_class6,
   input  logic signed [SCORE_W-1:0]  req_score_class7,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [CLASS_W-1:0]  rsp_gesture_class,
   output logic                       rsp_segment_done,
   output logic [FRAME_W-1:0]         rsp_start_frame,
   output logic [FRAME_W-1:0]         rsp_end_frame
);

   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SW = ENERGY_W + $clog2(WINDOW);
   localparam int LW = SW + 1;

   // ---------------- handshake control
   logic adv_o, mv2, free2, mv1, accept;

   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;

   assign adv_o     = !rsp_valid_ff || rsp_ready;
   assign mv2       = s2_valid_ff && adv_o;
   assign free2     = !s2_valid_ff || adv_o;
   assign mv1       = s1_valid_ff && free2;
   assign req_ready = !s1_valid_ff || free2;
   assign accept    = req_valid && req_ready;

   // ---------------- configuration
   logic [31:0] margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_wr_en) begin
         margin_ff <= csr_wr_data;
      end
   end

   logic signed [SCORE_W-1:0] req_scores [MAX_CLASSES];
   assign req_scores[0] = req_score_class0;
   assign req_scores[1] = req_score_class1;
   assign req_scores[2] = req_score_class2;
   assign req_scores[3] = req_score_class3;
   assign req_scores[4] = req_score_class4;
   assign req_scores[5] = req_score_class5;
   assign req_scores[6] = req_score_class6;
   assign req_scores[7] = req_score_class7;

   // ---------------- front stage: frame counter, window addressing
   logic [FRAME_W-1:0] frame_count_ff;
   logic               first_flag_ff;
   logic               first_pass_ff;
   logic [AW-1:0]      head_ff;

   logic               is_steady;
   logic [AW:0]        fill_sum;
   logic [AW-1:0]      fill_addr;
   logic [AW-1:0]      head_next;
   kind_type           kind_in;
   logic [AW-1:0]      addr_in;
   logic [ENERGY_W:0]  margin_sum;
   logic [SW-1:0]      lhs_in;
   logic [LW-1:0]      endcmp_in;

   always_comb begin
      is_steady  = frame_count_ff >= FRAME_W'(WINDOW);
      fill_sum   = {1'b0, head_ff} + (AW+1)'(frame_count_ff[AW-1:0]);
      fill_addr  = (fill_sum >= (AW+1)'(WINDOW)) ? AW'(fill_sum - (AW+1)'(WINDOW))
                                                 : AW'(fill_sum);
      head_next  = (head_ff == AW'(WINDOW - 1)) ? '0 : head_ff + AW'(1);
      if (first_flag_ff) begin
         kind_in = KIND_FIRST;
      end else if (is_steady) begin
         kind_in = KIND_STEADY;
      end else begin
         kind_in = KIND_FILL;
      end
      addr_in    = (kind_in == KIND_STEADY) ? head_ff : fill_addr;
      margin_sum = {1'b0, req_motion_energy} + {1'b0, margin_ff};
      lhs_in     = SW'(SW'(req_motion_energy) * SW'(WINDOW));
      // end test W*e < sum - W*m rewritten as W*(e+m) < sum
      endcmp_in  = LW'(LW'(margin_sum) * LW'(WINDOW));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         first_flag_ff  <= 1'b1;
         first_pass_ff  <= 1'b1;
         head_ff        <= '0;
      end else if (accept) begin
         frame_count_ff <= frame_count_ff + FRAME_W'(1);
         if (kind_in == KIND_FIRST) begin
            first_flag_ff <= 1'b0;
         end
         if (kind_in == KIND_STEADY) begin
            first_pass_ff <= 1'b0;
            head_ff       <= head_next;
         end
      end
   end

   // ---------------- stage 1 registers
   kind_type                  s1_kind_ff;
   logic [AW-1:0]             s1_addr_ff;
   logic                      s1_zero_ff;
   logic [ENERGY_W-1:0]       s1_energy_ff;
   logic [SW-1:0]             s1_lhs_ff;
   logic [LW-1:0]             s1_endcmp_ff;
   logic [FRAME_W-1:0]        s1_first_frame_ff;
   logic [FRAME_W-1:0]        s1_fc_minus_w_ff;
   logic signed [SCORE_W-1:0] s1_scores_ff [MAX_CLASSES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (mv1) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff        <= kind_in;
         s1_addr_ff        <= addr_in;
         // slot 0 is not filled before the first full-window frame, which also sees zero
         s1_zero_ff        <= first_pass_ff;
         s1_energy_ff      <= req_motion_energy;
         s1_lhs_ff         <= lhs_in;
         s1_endcmp_ff      <= endcmp_in;
         s1_first_frame_ff <= frame_count_ff + FRAME_W'(1);
         s1_fc_minus_w_ff  <= frame_count_ff - FRAME_W'(WINDOW);
         s1_scores_ff      <= req_scores;
      end
   end

   // ---------------- energy window memory, circular from head_ff
   logic [ENERGY_W-1:0] window_mem [WINDOW];
   logic [ENERGY_W-1:0] energy_old_ff;
   logic                mem_we;

   assign mem_we = mv1 && (s1_kind_ff != KIND_FIRST);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[s1_addr_ff] <= s1_energy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         energy_old_ff <= window_mem[addr_in];
      end
   end

   // ---------------- stage 1: running sum and mean tests
   logic [SW-1:0]        window_sum_ff;
   logic                 quiet_ff;
   logic [FRAME_W-1:0]   segment_start_ff;

   logic [ENERGY_W-1:0]  old_energy;
   logic [SW-1:0]        sum_new;
   logic                 end_hit, start_hit;
   action_type           action_in;
   logic                 done_in;
   logic [FRAME_W-1:0]   sframe_in, eframe_in;

   always_comb begin
      old_energy = s1_zero_ff ? '0 : energy_old_ff;
      sum_new    = window_sum_ff - SW'(old_energy) + SW'(s1_energy_ff);
      end_hit    = s1_endcmp_ff < {1'b0, sum_new};
      start_hit  = s1_lhs_ff > sum_new;
      action_in  = ACT_NONE;
      done_in    = 1'b0;
      sframe_in  = '0;
      eframe_in  = '0;
      unique case (s1_kind_ff)
         KIND_FIRST: begin
            sframe_in = s1_first_frame_ff;
         end
         KIND_STEADY: begin
            if (!quiet_ff) begin
               if (end_hit) begin
                  action_in = ACT_END;
                  done_in   = 1'b1;
                  sframe_in = segment_start_ff;
                  eframe_in = s1_fc_minus_w_ff;
               end else begin
                  action_in = ACT_ACC;
               end
            end else if (start_hit) begin
               action_in = ACT_ACC;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_sum_ff    <= '0;
         quiet_ff         <= 1'b0;
         segment_start_ff <= '0;
      end else if (mv1) begin
         if (s1_kind_ff != KIND_FIRST) begin
            window_sum_ff <= sum_new;
         end
         if (s1_kind_ff == KIND_STEADY) begin
            if (!quiet_ff && end_hit) begin
               quiet_ff <= 1'b1;
            end else if (quiet_ff && start_hit) begin
               quiet_ff         <= 1'b0;
               segment_start_ff <= s1_fc_minus_w_ff;
            end
         end
      end
   end

   // ---------------- stage 2 registers
   action_type                s2_action_ff;
   logic                      s2_done_ff;
   logic [FRAME_W-1:0]        s2_sframe_ff, s2_eframe_ff;
   logic signed [SCORE_W-1:0] s2_scores_ff [MAX_CLASSES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (mv1) begin
         s2_valid_ff <= 1'b1;
      end else if (mv2) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mv1) begin
         s2_action_ff <= action_in;
         s2_done_ff   <= done_in;
         s2_sframe_ff <= sframe_in;
         s2_eframe_ff <= eframe_in;
         s2_scores_ff <= s1_scores_ff;
      end
   end

   // ---------------- stage 2: class lanes and argmax merge
   lane_ctrl_type           lane_ctrl;
   logic signed [SUM_W-1:0] lane_sums [NUM_CLASSES];
   logic                    nonempty_ff;
   logic signed [CLASS_W-1:0] winner;

   assign lane_ctrl.acc = mv2 && (s2_action_ff == ACT_ACC);
   assign lane_ctrl.clr = mv2 && (s2_action_ff == ACT_END);

   for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
      gmgs_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl),
         .score (s2_scores_ff[c]),
         .sum   (lane_sums[c])
      );
   end

   gmgs_argmax #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_argmax (
      .sums     (lane_sums),
      .nonempty (nonempty_ff),
      .winner   (winner)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= 1'b0;
      end else if (lane_ctrl.clr) begin
         nonempty_ff <= 1'b0;
      end else if (lane_ctrl.acc) begin
         nonempty_ff <= 1'b1;
      end
   end

   // ---------------- output register
   logic signed [CLASS_W-1:0] rsp_class_ff;
   logic                      rsp_done_ff;
   logic [FRAME_W-1:0]        rsp_sframe_ff, rsp_eframe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mv2) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mv2) begin
         rsp_class_ff  <= (s2_action_ff == ACT_END) ? winner : NO_CLASS;
         rsp_done_ff   <= s2_done_ff;
         rsp_sframe_ff <= s2_sframe_ff;
         rsp_eframe_ff <= s2_eframe_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gesture_class = rsp_class_ff;
   assign rsp_segment_done  = rsp_done_ff;
   assign rsp_start_frame   = rsp_sframe_ff;
   assign rsp_end_frame     = rsp_eframe_ff;

endmodule

/* rtl/gmgs_lane.sv */
// gmgs_lane: one class lane, a saturating 40-bit score accumulator
// depends on gmgs_pkg
module gmgs_lane
   import gmgs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctrl_type             ctrl,
   input  logic signed [SCORE_W-1:0] score,
   output logic signed [SUM_W-1:0]   sum
);

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W:0]   wide;

   always_comb begin
      wide   = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(score);
      sum_in = sum_ff;
      if (ctrl.clr) begin
         sum_in = '0;
      end else if (ctrl.acc) begin
         if (wide > (SUM_W+1)'(SUM_MAX)) begin
            sum_in = SUM_MAX;
         end else if (wide < (SUM_W+1)'(SUM_MIN)) begin
            sum_in = SUM_MIN;
         end else begin
            sum_in = wide[SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

/* rtl/gmgs_argmax.sv */
// gmgs_argmax: merges the lane sums into the first strict argmax above the floor
// -1 while nonempty is low; depends on gmgs_pkg
module gmgs_argmax
   import gmgs_pkg::*;
#(
   parameter int NUM_CLASSES = DEFAULT_NUM_CLASSES
)
(
   input  logic signed [SUM_W-1:0]   sums [NUM_CLASSES],
   input  logic                      nonempty,
   output logic signed [CLASS_W-1:0] winner
);

   logic signed [SUM_W-1:0]   best;
   logic signed [CLASS_W-1:0] idx;

   always_comb begin
      best = ARGMAX_FLOOR;
      idx  = NO_CLASS;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (sums[c] > best) begin
            best = sums[c];
            idx  = CLASS_W'(c);
         end
      end
      winner = nonempty ? idx : NO_CLASS;
   end

endmodule
